// ===== hdl/sap_pkg.sv =====
// shared types, constants and helper functions for the axis positioner
package sap_pkg;

	localparam int POSITION_WIDTH = 16;
	localparam int TARGET_W       = 13;
	localparam int ITER_W         = 12;
	localparam int LIMIT_W        = 16;
	localparam int APB_DATA_W     = 32;
	localparam int APB_ADDR_W     = 5;
	localparam int REG_IDX_W      = 3;

	// widths for the compares, wide enough for either operand
	localparam int CMP_W = (POSITION_WIDTH > LIMIT_W) ? POSITION_WIDTH : LIMIT_W;
	localparam int ERR_W = ((POSITION_WIDTH > TARGET_W) ? POSITION_WIDTH : TARGET_W) + 1;

	localparam logic [TARGET_W-1:0] TARGET_RST    = '0;
	localparam logic [TARGET_W-1:0] TOLERANCE_RST = '0;
	localparam logic [ITER_W-1:0]   MAX_ITER_RST  = ITER_W'(1500);
	localparam logic [LIMIT_W-1:0]  LIMIT_RST     = LIMIT_W'(5000);

	typedef enum logic {
		OP_START  = 1'b0,
		OP_SAMPLE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ACT_NONE   = 2'd0,
		ACT_STEP_X = 2'd1,
		ACT_STEP_Y = 2'd2,
		ACT_STEP_Z = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ERR_NONE    = 2'd0,
		ERR_STOP    = 2'd1,
		ERR_SENSOR  = 2'd2,
		ERR_TIMEOUT = 2'd3
	} err_code_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_TARGET_X  = 3'd0,
		REG_TARGET_Y  = 3'd1,
		REG_TARGET_Z  = 3'd2,
		REG_TOLERANCE = 3'd3,
		REG_MAX_ITER  = 3'd4,
		REG_LIMIT     = 3'd5
	} reg_idx_t;

	typedef struct packed {
		op_t                       op;
		logic                      stop_request;
		logic [POSITION_WIDTH-1:0] x_position;
		logic [POSITION_WIDTH-1:0] y_position;
		logic [POSITION_WIDTH-1:0] z_position;
	} item_t;

	typedef struct packed {
		action_t   action;
		logic      direction;
		logic      busy_res;
		logic      done_res;
		logic      error_flag;
		err_code_t error_code;
	} result_t;

	typedef struct packed {
		logic [TARGET_W-1:0] target_x;
		logic [TARGET_W-1:0] target_y;
		logic [TARGET_W-1:0] target_z;
		logic [TARGET_W-1:0] tolerance;
		logic [ITER_W-1:0]   max_iterations;
		logic [LIMIT_W-1:0]  valid_limit;
	} cfg_t;

	typedef struct packed {
		logic              busy_flag;
		logic              error_state;
		err_code_t         last_error;
		logic [ITER_W-1:0] iteration_count;
	} state_t;

	// signed error of one axis, target minus position
	function automatic logic signed [ERR_W-1:0] axis_err(
		input logic [TARGET_W-1:0]       tgt,
		input logic [POSITION_WIDTH-1:0] pos
	);
		return $signed(ERR_W'(tgt)) - $signed(ERR_W'(pos));
	endfunction

	// magnitude within tolerance, inclusive
	function automatic logic axis_ok(
		input logic signed [ERR_W-1:0] err,
		input logic [TARGET_W-1:0]     tol
	);
		logic [ERR_W-1:0] mag;
		mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
		return mag <= ERR_W'(tol);
	endfunction

endpackage

// ===== hdl/sequential_axis_positioner.sv =====
// top level of the three-axis bang-bang positioner
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-----------------------
//  item     | in        | item_valid/item_ready  | item (op, stop, x/y/z)
//  result   | out       | result_valid/ready     | result (action, status)
//  config   | in        | apb psel/penable       | six registers at 4*i
//
// one transaction per cycle sustained while results are taken; a result is offered once
// its item has passed the input register and then the result register
// the move state is updated in the same edge that loads the result register,
// so the next item in the input register always sees the current state
// reset clears the state, the registers to their defaults and both valid flags
// a stalled result holds the input register, and the input register holds
// the item channel, so nothing is lost or repeated under back-pressure
module sequential_axis_positioner (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [sap_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [sap_pkg::APB_DATA_W-1:0] pwdata,
	output logic [sap_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  sap_pkg::item_t                 item,
	output logic                           result_valid,
	input  logic                           result_ready,
	output sap_pkg::result_t               result
);
	import sap_pkg::*;

	cfg_t    cfg;
	// input register stage
	item_t   item_s1;
	logic    item_valid_s1;
	// result register
	result_t result_q;
	logic    result_valid_q;
	// move state
	state_t  state_q;
	state_t  state_next;
	result_t res_next;
	logic    advance;

	sap_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sap_decide u_decide (
		.item    (item_s1),
		.cfg     (cfg),
		.st      (state_q),
		.st_next (state_next),
		.res     (res_next)
	);

	// the registered item moves on when the result register is free or draining
	assign advance    = item_valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !item_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (item_ready) begin
			item_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= res_next;
		end
	end

	// state commits only when its item's result is committed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.busy_flag       <= 1'b0;
			state_q.error_state     <= 1'b0;
			state_q.last_error      <= ERR_NONE;
			state_q.iteration_count <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== hdl/sap_regs.sv =====
// apb configuration register file for the axis positioner
module sap_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [sap_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [sap_pkg::APB_DATA_W-1:0] pwdata,
	output logic [sap_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	output sap_pkg::cfg_t                  cfg
);
	import sap_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_x       <= TARGET_RST;
			cfg_q.target_y       <= TARGET_RST;
			cfg_q.target_z       <= TARGET_RST;
			cfg_q.tolerance      <= TOLERANCE_RST;
			cfg_q.max_iterations <= MAX_ITER_RST;
			cfg_q.valid_limit    <= LIMIT_RST;
		end else if (wr_en) begin
			case (idx)
				REG_TARGET_X:  cfg_q.target_x       <= pwdata[TARGET_W-1:0];
				REG_TARGET_Y:  cfg_q.target_y       <= pwdata[TARGET_W-1:0];
				REG_TARGET_Z:  cfg_q.target_z       <= pwdata[TARGET_W-1:0];
				REG_TOLERANCE: cfg_q.tolerance      <= pwdata[TARGET_W-1:0];
				REG_MAX_ITER:  cfg_q.max_iterations <= pwdata[ITER_W-1:0];
				REG_LIMIT:     cfg_q.valid_limit    <= pwdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_TARGET_X:  prdata = APB_DATA_W'(cfg_q.target_x);
			REG_TARGET_Y:  prdata = APB_DATA_W'(cfg_q.target_y);
			REG_TARGET_Z:  prdata = APB_DATA_W'(cfg_q.target_z);
			REG_TOLERANCE: prdata = APB_DATA_W'(cfg_q.tolerance);
			REG_MAX_ITER:  prdata = APB_DATA_W'(cfg_q.max_iterations);
			REG_LIMIT:     prdata = APB_DATA_W'(cfg_q.valid_limit);
			default:       prdata = '0;
		endcase
	end

endmodule

// ===== hdl/sap_decide.sv =====
// per-item decision logic: next state and result from one registered item
module sap_decide (
	input  sap_pkg::item_t   item,
	input  sap_pkg::cfg_t    cfg,
	input  sap_pkg::state_t  st,
	output sap_pkg::state_t  st_next,
	output sap_pkg::result_t res
);
	import sap_pkg::*;

	logic                    invalid;
	logic signed [ERR_W-1:0] dx, dy, dz;
	logic                    xok, yok, zok;
	logic [ITER_W-1:0]       iter_inc;
	action_t                 act;
	logic                    dir;
	logic                    done;

	assign invalid = (CMP_W'(item.x_position) > CMP_W'(cfg.valid_limit))
	              || (CMP_W'(item.y_position) > CMP_W'(cfg.valid_limit))
	              || (CMP_W'(item.z_position) > CMP_W'(cfg.valid_limit));

	assign dx  = axis_err(cfg.target_x, item.x_position);
	assign dy  = axis_err(cfg.target_y, item.y_position);
	assign dz  = axis_err(cfg.target_z, item.z_position);
	assign xok = axis_ok(dx, cfg.tolerance);
	assign yok = axis_ok(dy, cfg.tolerance);
	assign zok = axis_ok(dz, cfg.tolerance);

	assign iter_inc = st.iteration_count + ITER_W'(1);

	always_comb begin
		st_next = st;
		act     = ACT_NONE;
		dir     = 1'b0;
		done    = 1'b0;
		priority if (item.op == OP_START) begin
			st_next.error_state     = 1'b0;
			st_next.last_error      = ERR_NONE;
			st_next.busy_flag       = 1'b1;
			st_next.iteration_count = '0;
		end else if (st.busy_flag) begin
			priority if (item.stop_request) begin
				st_next.busy_flag   = 1'b0;
				st_next.error_state = 1'b1;
				st_next.last_error  = ERR_STOP;
			end else if (invalid) begin
				st_next.busy_flag   = 1'b0;
				st_next.error_state = 1'b1;
				st_next.last_error  = ERR_SENSOR;
			end else if (xok && yok && zok) begin
				st_next.busy_flag  = 1'b0;
				st_next.last_error = ERR_NONE;
				done               = 1'b1;
			end else begin
				// first axis out of band wins, y pin inverted
				priority if (!xok) begin
					act = ACT_STEP_X;
					dir = !dx[ERR_W-1] && (dx != '0);
				end else if (!yok) begin
					act = ACT_STEP_Y;
					dir = dy[ERR_W-1] || (dy == '0);
				end else begin
					act = ACT_STEP_Z;
					dir = !dz[ERR_W-1] && (dz != '0);
				end
				st_next.iteration_count = iter_inc;
				if (iter_inc >= cfg.max_iterations) begin
					st_next.busy_flag   = 1'b0;
					st_next.error_state = 1'b1;
					st_next.last_error  = ERR_TIMEOUT;
				end
			end
		end
	end

	always_comb begin
		res.action     = act;
		res.direction  = dir;
		res.busy_res   = st_next.busy_flag;
		res.done_res   = done;
		res.error_flag = st_next.error_state;
		res.error_code = st_next.last_error;
	end

endmodule

// ===== verif/tb_sequential_axis_positioner.sv =====
// self-checking testbench for the three-axis bang-bang positioner
module tb_sequential_axis_positioner;
	import sap_pkg::*;

	localparam int HOLD_CYCLES    = 150;  // long receiver hold-off, fills the pipeline
	localparam int WATCHDOG_LIMIT = 3000; // cycles with no transaction on either channel
	localparam int SETTLE_CYCLES  = 4;    // two-stage pipeline plus margin
	localparam int PHASES         = 10;
	localparam int PHASE_ITEMS    = 125;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// configuration port
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	// item and result channels
	logic    item_valid = 1'b0;
	logic    item_ready;
	item_t   item_bus = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result_bus;

	// items waiting to be offered, and results the positioner owes us
	item_t   item_backlog[$];
	result_t expected_moves[$];

	// our own copy of the registers and of the move state
	cfg_t        shadow_cfg;
	logic        mv_busy = 1'b0;
	logic        mv_error = 1'b0;
	err_code_t   mv_code = ERR_NONE;
	logic [11:0] mv_iter = '0;

	// sender burst shaping
	int burst_left = 0;
	int gap_left = 0;

	// receiver pattern and hold-off bookkeeping
	int hold_requests = 0;
	int holds_granted = 0;
	int hold_left = 0;
	int ready_mode = 0;
	int mode_left = 0;

	int stall_cycles = 0;
	int mismatch_count = 0;
	int items_in = 0;
	int results_out = 0;
	int done_total = 0;
	int stop_total = 0;
	int sensor_total = 0;
	int timeout_total = 0;

	sequential_axis_positioner dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item_bus),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result_bus)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// predicts one result from one accepted transaction and advances the move state
	function automatic result_t advance_positioner(input item_t it);
		result_t r;
		int dx;
		int dy;
		int dz;
		logic x_in;
		logic y_in;
		logic z_in;
		r = '0;
		if (it.op == OP_START) begin
			// start clears the status; stop request means nothing here
			mv_error = 1'b0;
			mv_code = ERR_NONE;
			mv_busy = 1'b1;
			mv_iter = '0;
		end else if (mv_busy) begin
			if (it.stop_request) begin
				mv_busy = 1'b0;
				mv_error = 1'b1;
				mv_code = ERR_STOP;
				stop_total++;
			end else if (it.x_position > shadow_cfg.valid_limit
					|| it.y_position > shadow_cfg.valid_limit
					|| it.z_position > shadow_cfg.valid_limit) begin
				mv_busy = 1'b0;
				mv_error = 1'b1;
				mv_code = ERR_SENSOR;
				sensor_total++;
			end else begin
				dx = int'(shadow_cfg.target_x) - int'(it.x_position);
				dy = int'(shadow_cfg.target_y) - int'(it.y_position);
				dz = int'(shadow_cfg.target_z) - int'(it.z_position);
				x_in = ((dx < 0) ? -dx : dx) <= int'(shadow_cfg.tolerance);
				y_in = ((dy < 0) ? -dy : dy) <= int'(shadow_cfg.tolerance);
				z_in = ((dz < 0) ? -dz : dz) <= int'(shadow_cfg.tolerance);
				if (x_in && y_in && z_in) begin
					mv_busy = 1'b0;
					mv_code = ERR_NONE;
					r.done_res = 1'b1;
					done_total++;
				end else begin
					// first axis out of band wins; y pin sense is inverted
					if (!x_in) begin
						r.action = ACT_STEP_X;
						r.direction = dx > 0;
					end else if (!y_in) begin
						r.action = ACT_STEP_Y;
						r.direction = !(dy > 0);
					end else begin
						r.action = ACT_STEP_Z;
						r.direction = dz > 0;
					end
					mv_iter = mv_iter + 12'd1;
					// the last permitted move still goes out, flagged as timeout
					if (mv_iter >= shadow_cfg.max_iterations) begin
						mv_busy = 1'b0;
						mv_error = 1'b1;
						mv_code = ERR_TIMEOUT;
						timeout_total++;
					end
				end
			end
		end
		// idle samples fall through and just report the held status
		r.busy_res = mv_busy;
		r.error_flag = mv_error;
		r.error_code = mv_code;
		return r;
	endfunction

	function automatic item_t pack_item(input op_t op, input logic stop,
			input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
		item_t it;
		it.op = op;
		it.stop_request = stop;
		it.x_position = x;
		it.y_position = y;
		it.z_position = z;
		return it;
	endfunction

	// a sensor reading that is in band half the time, otherwise near the target or anywhere
	function automatic logic [15:0] reading_near(input int tgt, input int tol);
		int p;
		case ($urandom_range(0, 3))
			0, 1: p = tgt - tol + int'($urandom_range(0, 2 * tol));
			2: p = tgt + int'($urandom_range(0, 400)) - 200;
			default: p = int'($urandom_range(0, 9000));
		endcase
		if (p < 0)
			p = 0;
		return 16'(p);
	endfunction

	task automatic note_fault(input string why, input result_t want, input result_t got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("[%0t] %s: expected act=%0d dir=%0d busy=%0d done=%0d err=%0d code=%0d",
				$realtime, why, want.action, want.direction, want.busy_res, want.done_res,
				want.error_flag, want.error_code);
			$display("[%0t] %s: actual   act=%0d dir=%0d busy=%0d done=%0d err=%0d code=%0d",
				$realtime, why, got.action, got.direction, got.busy_res, got.done_res,
				got.error_flag, got.error_code);
		end
	endtask

	// setup cycle then access cycle; upper pwdata bits are junk the block must drop
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		logic [31:0] keep;
		case (idx)
			REG_MAX_ITER: keep = 32'h0000_0FFF;
			REG_LIMIT: keep = 32'h0000_FFFF;
			default: keep = 32'h0000_1FFF;
		endcase
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= ($urandom & ~keep) | (value & keep);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_TARGET_X: shadow_cfg.target_x = value[12:0];
			REG_TARGET_Y: shadow_cfg.target_y = value[12:0];
			REG_TARGET_Z: shadow_cfg.target_z = value[12:0];
			REG_TOLERANCE: shadow_cfg.tolerance = value[12:0];
			REG_MAX_ITER: shadow_cfg.max_iterations = value[11:0];
			default: shadow_cfg.valid_limit = value[15:0];
		endcase
	endtask

	task automatic program_settings(input int tx, input int ty, input int tz, input int tol,
			input int max_it, input int limit);
		write_reg(REG_TARGET_X, 32'(tx));
		write_reg(REG_TARGET_Y, 32'(ty));
		write_reg(REG_TARGET_Z, 32'(tz));
		write_reg(REG_TOLERANCE, 32'(tol));
		write_reg(REG_MAX_ITER, 32'(max_it));
		write_reg(REG_LIMIT, 32'(limit));
		// back off the rising edge before touching the backlog again
		@(negedge clk);
	endtask

	// everything offered, everything answered, then a settling wait for the pipeline
	task automatic wait_idle();
		do @(negedge clk);
		while (item_backlog.size() != 0 || item_valid || expected_moves.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// sender: bursts of random length with random gaps, valid held until taken
	always @(posedge clk) begin
		if (!(item_valid && !item_ready)) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				item_valid <= 1'b0;
			end else if (item_backlog.size() != 0) begin
				item_bus <= item_backlog.pop_front();
				item_valid <= 1'b1;
				if (burst_left > 1) begin
					burst_left <= burst_left - 1;
				end else begin
					burst_left <= $urandom_range(1, 32);
					// a quarter of bursts run straight into the next one
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// receiver: its own stall pattern, switched when its mode counter runs out, plus requested hold-offs
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			result_ready <= 1'b0;
		end else if (holds_granted != hold_requests) begin
			holds_granted <= holds_granted + 1;
			hold_left <= HOLD_CYCLES;
			result_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				ready_mode <= $urandom_range(0, 3);
				mode_left <= 64;
			end else begin
				mode_left <= mode_left - 1;
			end
			case (ready_mode)
				0: result_ready <= 1'b1;
				1: result_ready <= 1'($urandom_range(0, 1));
				2: result_ready <= ($urandom_range(0, 9) != 0);
				default: result_ready <= (mode_left % 3 == 0);
			endcase
		end
	end

	// monitor: predicts on each accepted item first, then checks each accepted result
	always @(posedge clk) begin : monitor
		result_t want;
		if (item_valid && item_ready) begin
			expected_moves.push_back(advance_positioner(item_bus));
			items_in++;
		end
		if (result_valid && result_ready) begin
			results_out++;
			if (expected_moves.size() == 0) begin
				note_fault("result with nothing outstanding", '0, result_bus);
			end else begin
				want = expected_moves.pop_front();
				if (result_bus.action !== want.action
						|| result_bus.direction !== want.direction
						|| result_bus.busy_res !== want.busy_res
						|| result_bus.done_res !== want.done_res
						|| result_bus.error_flag !== want.error_flag
						|| result_bus.error_code !== want.error_code)
					note_fault("result mismatch", want, result_bus);
			end
		end
	end

	// watchdog: a run with no transaction for too long is hung
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("Test completed with failures");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin : stimulus
		int queued;
		int n_samples;
		int roll;
		int tx;
		int ty;
		int tz;
		int tol;
		int max_it;
		int limit;
		item_t it;

		// register defaults after reset
		shadow_cfg.target_x = TARGET_RST;
		shadow_cfg.target_y = TARGET_RST;
		shadow_cfg.target_z = TARGET_RST;
		shadow_cfg.tolerance = TOLERANCE_RST;
		shadow_cfg.max_iterations = MAX_ITER_RST;
		shadow_cfg.valid_limit = LIMIT_RST;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, at reset defaults: targets 0, tolerance 0, limit 5000
		item_backlog.push_back(pack_item(OP_SAMPLE, 1'b0, 16'd0, 16'd0, 16'd0));   // idle sample
		item_backlog.push_back(pack_item(OP_START, 1'b1, 16'd9, 16'd9, 16'd9));    // stop ignored
		item_backlog.push_back(pack_item(OP_SAMPLE, 1'b1, 16'd0, 16'd0, 16'd0));   // stopped
		item_backlog.push_back(pack_item(OP_SAMPLE, 1'b1, 16'd0, 16'd0, 16'd0));   // held stop
		item_backlog.push_back(pack_item(OP_START, 1'b0, 16'd0, 16'd0, 16'd0));
		item_backlog.push_back(pack_item(OP_SAMPLE, 1'b0, 16'd5001, 16'd0, 16'd0)); // just over
		item_backlog.push_back(pack_item(OP_START, 1'b0, 16'd0, 16'd0, 16'd0));
		item_backlog.push_back(pack_item(OP_SAMPLE, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		item_backlog.push_back(pack_item(OP_START, 1'b0, 16'd0, 16'd0, 16'd0));
		item_backlog.push_back(pack_item(OP_SAMPLE, 1'b0, 16'd5000, 16'd0, 16'd0)); // x back
		item_backlog.push_back(pack_item(OP_SAMPLE, 1'b0, 16'd0, 16'd5000, 16'd0)); // y inverted
		item_backlog.push_back(pack_item(OP_SAMPLE, 1'b0, 16'd0, 16'd0, 16'd1));    // z back
		item_backlog.push_back(pack_item(OP_START, 1'b0, 16'd0, 16'd0, 16'd0));     // restart
		item_backlog.push_back(pack_item(OP_SAMPLE, 1'b0, 16'd7, 16'd5000, 16'd0));
		item_backlog.push_back(pack_item(OP_SAMPLE, 1'b0, 16'd0, 16'd0, 16'd0));    // done
		item_backlog.push_back(pack_item(OP_SAMPLE, 1'b0, 16'd3, 16'd3, 16'd3));    // idle after done
		wait_idle();

		// zero iteration budget: the first move times out at once
		program_settings(5000, 5000, 5000, 0, 0, 65535);
		item_backlog.push_back(pack_item(OP_START, 1'b0, 16'd0, 16'd0, 16'd0));
		item_backlog.push_back(pack_item(OP_SAMPLE, 1'b0, 16'd0, 16'd0, 16'd0));
		item_backlog.push_back(pack_item(OP_SAMPLE, 1'b0, 16'd0, 16'd0, 16'd0));
		item_backlog.push_back(pack_item(OP_START, 1'b0, 16'd0, 16'd0, 16'd0));
		item_backlog.push_back(pack_item(OP_SAMPLE, 1'b0, 16'd5000, 16'd0, 16'd5000));
		item_backlog.push_back(pack_item(OP_START, 1'b0, 16'd0, 16'd0, 16'd0));
		item_backlog.push_back(pack_item(OP_SAMPLE, 1'b0, 16'd5000, 16'd5000, 16'd4999));
		wait_idle();

		// widest tolerance and a zero validity limit
		program_settings(8191, 10, 10, 8191, 4095, 0);
		item_backlog.push_back(pack_item(OP_START, 1'b0, 16'd0, 16'd0, 16'd0));
		item_backlog.push_back(pack_item(OP_SAMPLE, 1'b0, 16'd0, 16'd0, 16'd0));
		item_backlog.push_back(pack_item(OP_START, 1'b0, 16'd0, 16'd0, 16'd0));
		item_backlog.push_back(pack_item(OP_SAMPLE, 1'b0, 16'd0, 16'd1, 16'd0));
		wait_idle();

		// random phases, each with its own register settings
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: program_settings(0, 0, 0, 0, 1, 65535);
				1: program_settings(8191, 8191, 8191, 0, 4095, 65535);
				2: program_settings(2500, 1200, 4000, 20, 0, 5000);
				default: begin
					tx = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 5000);
					ty = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 5000);
					tz = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 5000);
					roll = $urandom_range(0, 9);
					tol = (roll < 2) ? 0 : (roll < 7) ? $urandom_range(1, 50)
						: (roll < 9) ? $urandom_range(51, 5000) : $urandom_range(0, 8191);
					roll = $urandom_range(0, 9);
					max_it = (roll == 0) ? 0 : (roll == 1) ? 1 : (roll < 7) ? $urandom_range(2, 25)
						: (roll == 7) ? 4095 : $urandom_range(0, 4095);
					roll = $urandom_range(0, 9);
					limit = (roll < 6) ? 65535 : (roll < 8) ? $urandom_range(5000, 65535)
						: (roll == 8) ? $urandom_range(0, 65535) : 5000;
					program_settings(tx, ty, tz, tol, max_it, limit);
				end
			endcase

			// long receiver hold-off while the sender keeps offering
			if (phase == 4 || phase == 8)
				hold_requests++;

			queued = 0;
			while (queued < PHASE_ITEMS) begin
				if ($urandom_range(0, 99) < 15) begin
					// noise: any op, any stop, full-range readings
					item_backlog.push_back(pack_item(op_t'(1'($urandom_range(0, 1))),
						1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom), 16'($urandom)));
				end else begin
					// well-formed move: a start and a run of samples around the target
					n_samples = $urandom_range(1, 14);
					item_backlog.push_back(pack_item(OP_START, 1'($urandom_range(0, 1)),
						16'($urandom), 16'($urandom), 16'($urandom)));
					repeat (n_samples) begin
						roll = $urandom_range(0, 99);
						it = pack_item(OP_SAMPLE, roll < 3,
							reading_near(int'(shadow_cfg.target_x), int'(shadow_cfg.tolerance)),
							reading_near(int'(shadow_cfg.target_y), int'(shadow_cfg.tolerance)),
							reading_near(int'(shadow_cfg.target_z), int'(shadow_cfg.tolerance)));
						// now and then a reading beyond the validity limit on one axis
						if (roll >= 3 && roll < 6 && shadow_cfg.valid_limit != 16'hFFFF) begin
							case ($urandom_range(0, 2))
								0: it.x_position = 16'($urandom_range(int'(shadow_cfg.valid_limit) + 1, 65535));
								1: it.y_position = 16'($urandom_range(int'(shadow_cfg.valid_limit) + 1, 65535));
								default: it.z_position = 16'($urandom_range(int'(shadow_cfg.valid_limit) + 1, 65535));
							endcase
						end
						item_backlog.push_back(it);
					end
					queued += n_samples + 1;
				end
			end
			wait_idle();
		end

		$display("covered %0d transactions in and %0d results checked over %0d settings",
			items_in, results_out, PHASES + 3);
		$display("moves ended: %0d done, %0d stopped, %0d sensor invalid, %0d timed out",
			done_total, stop_total, sensor_total, timeout_total);
		if (mismatch_count == 0 && expected_moves.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d mismatches, %0d results still outstanding",
				mismatch_count, expected_moves.size());
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/sap_pkg.sv
hdl/sap_regs.sv
hdl/sap_decide.sv
hdl/sequential_axis_positioner.sv
verif/tb_sequential_axis_positioner.sv
